[rtl/hht_pkg.sv]
`timescale 1ns / 1ps

package hht_pkg;

  localparam int NUM_SQUARES = 64;
  localparam int TBL_DEPTH = NUM_SQUARES * NUM_SQUARES;
  localparam int ADDR_W = $clog2(TBL_DEPTH);

  localparam int HIST_LIMIT = 16384;
  localparam int LIMIT_SH = $clog2(HIST_LIMIT);
  localparam int BONUS_CAP = 2100;
  localparam int BONUS_STEP = 300;
  localparam int REWARD_MIN_DEPTH = 2;

  localparam int FUNC_W = 2;
  localparam int SQ_FIELD_W = 6;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 16;

  // Raw bonus 300*depth-300 needs 17 signed bits; the capped bonus fits 13.
  localparam int RAW_W = 17;
  localparam int BONUS_W = 13;
  localparam int MAG_W = BONUS_W - 1;
  localparam int PROD_W = 29;
  localparam int SUM_W = 18;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_REWARD   = 2'd0,
    FUNC_PENALIZE = 2'd1,
    FUNC_READ     = 2'd2
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;     // write zero at the sweep address and advance it
    logic load;    // capture a request and read its table entry
    logic mul;     // register entry times bonus magnitude
    logic commit;  // write back the entry and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the sweep is at the final table entry
  } status_t;

endpackage

[rtl/hht_ctrl.sv]
`timescale 1ns / 1ps

module hht_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  hht_pkg::status_t status,
  output hht_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_WB
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd.clr    = (state_r == S_CLEAR);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.mul    = (state_r == S_MUL);
    cmd.commit = (state_r == S_WB) && slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/hht_dp.sv]
`timescale 1ns / 1ps

module hht_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hht_pkg::cmd_t                        cmd,
  output hht_pkg::status_t                     status,
  input  logic        [hht_pkg::FUNC_W-1:0]     in_func,
  input  logic        [hht_pkg::SQ_FIELD_W-1:0] in_from_square,
  input  logic        [hht_pkg::SQ_FIELD_W-1:0] in_to_square,
  input  logic        [hht_pkg::DEPTH_W-1:0]    in_depth,
  output logic signed [hht_pkg::SCORE_W-1:0]    out_score
);

  localparam logic signed [hht_pkg::SUM_W-1:0] LIM_P = hht_pkg::SUM_W'(hht_pkg::HIST_LIMIT);
  localparam logic signed [hht_pkg::SUM_W-1:0] LIM_N = -LIM_P;

  logic signed [hht_pkg::SCORE_W-1:0] mem [hht_pkg::TBL_DEPTH];

  logic        [hht_pkg::ADDR_W-1:0]  clr_cnt_r;
  logic        [hht_pkg::ADDR_W-1:0]  addr_r;
  logic signed [hht_pkg::SCORE_W-1:0] h_r;
  logic signed [hht_pkg::BONUS_W-1:0] target_r;
  logic        [hht_pkg::MAG_W-1:0]   mag_r;
  logic                               upd_r;
  logic                               oor_r;
  logic signed [hht_pkg::PROD_W-1:0]  prod_r;
  logic signed [hht_pkg::SCORE_W-1:0] score_r;

  logic        [hht_pkg::ADDR_W-1:0]  addr_in;
  logic                               oor_in;
  logic signed [hht_pkg::RAW_W-1:0]   bonus_raw;
  logic signed [hht_pkg::BONUS_W-1:0] bonus;
  logic        [hht_pkg::MAG_W-1:0]   mag_in;
  logic signed [hht_pkg::BONUS_W-1:0] target_in;
  logic                               upd_in;
  logic signed [hht_pkg::PROD_W-1:0]  h_ext;
  logic signed [hht_pkg::PROD_W-1:0]  mag_ext;
  logic signed [hht_pkg::PROD_W-1:0]  prod_adj;
  logic signed [hht_pkg::PROD_W-1:0]  prod_sh;
  logic signed [hht_pkg::SUM_W-1:0]   sum;
  logic signed [hht_pkg::SUM_W-1:0]   sum_sat;
  logic signed [hht_pkg::SCORE_W-1:0] result;

  assign status.clr_last = (clr_cnt_r == hht_pkg::ADDR_W'(hht_pkg::TBL_DEPTH - 1));

  // Request decode: table address, range check and bonus.
  always_comb begin
    addr_in = hht_pkg::ADDR_W'(hht_pkg::ADDR_W'(in_from_square) *
                               hht_pkg::ADDR_W'(hht_pkg::NUM_SQUARES)) +
              hht_pkg::ADDR_W'(in_to_square);
    oor_in = (32'(in_from_square) >= hht_pkg::NUM_SQUARES) ||
             (32'(in_to_square) >= hht_pkg::NUM_SQUARES);
    bonus_raw = $signed(hht_pkg::RAW_W'(in_depth)) * hht_pkg::RAW_W'(hht_pkg::BONUS_STEP) -
                hht_pkg::RAW_W'(hht_pkg::BONUS_STEP);
    if (bonus_raw > hht_pkg::RAW_W'(hht_pkg::BONUS_CAP)) begin
      bonus = hht_pkg::BONUS_W'(hht_pkg::BONUS_CAP);
    end else begin
      bonus = hht_pkg::BONUS_W'(bonus_raw);
    end
    mag_in    = bonus[hht_pkg::BONUS_W-1] ? hht_pkg::MAG_W'(-bonus) : hht_pkg::MAG_W'(bonus);
    target_in = (in_func == hht_pkg::FUNC_PENALIZE) ? -bonus : bonus;
    upd_in    = ((in_func == hht_pkg::FUNC_REWARD) &&
                 (32'(in_depth) > hht_pkg::REWARD_MIN_DEPTH)) ||
                (in_func == hht_pkg::FUNC_PENALIZE);
  end

  // Gravity step: h + target - h*|B|/16384 with the quotient rounded toward zero.
  always_comb begin
    h_ext    = hht_pkg::PROD_W'(h_r);
    mag_ext  = hht_pkg::PROD_W'($signed({1'b0, mag_r}));
    prod_adj = prod_r + (prod_r[hht_pkg::PROD_W-1] ?
                         hht_pkg::PROD_W'(hht_pkg::HIST_LIMIT - 1) : '0);
    prod_sh  = prod_adj >>> hht_pkg::LIMIT_SH;
    sum      = hht_pkg::SUM_W'(h_r) + hht_pkg::SUM_W'(target_r) -
               hht_pkg::SUM_W'(prod_sh);
    if (sum > LIM_P) begin
      sum_sat = LIM_P;
    end else if (sum < LIM_N) begin
      sum_sat = LIM_N;
    end else begin
      sum_sat = sum;
    end
    if (oor_r) begin
      result = '0;
    end else if (upd_r) begin
      result = hht_pkg::SCORE_W'(sum_sat);
    end else begin
      result = h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && upd_r && !oor_r) begin
      mem[addr_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r      <= mem[addr_in];
      addr_r   <= addr_in;
      target_r <= target_in;
      mag_r    <= mag_in;
      upd_r    <= upd_in;
      oor_r    <= oor_in;
    end
    if (cmd.mul) begin
      prod_r <= h_ext * mag_ext;
    end
    if (cmd.commit) begin
      score_r <= result;
    end
  end

  assign out_score = score_r;

endmodule

[rtl/history_heuristic_table_update.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_func, in_from_square, in_to_square, in_depth
// out      output     out_valid / out_ready  out_score
//
// A request takes three steps: accept with the table read,
// the entry times bonus multiply, then saturating write back into the output register.
// The steps are set by the single-port table read-modify-write and the registered multiply.
// After reset a clearing pass zeroes the table's NUM_SQUARES squared entries (4096),
// one entry a cycle; in_ready stays low until it ends.
// A result held by a stalled out_ready only blocks the write-back step of the next request.

module history_heuristic_table_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [hht_pkg::FUNC_W-1:0]     in_func,
  input  logic        [hht_pkg::SQ_FIELD_W-1:0] in_from_square,
  input  logic        [hht_pkg::SQ_FIELD_W-1:0] in_to_square,
  input  logic        [hht_pkg::DEPTH_W-1:0]    in_depth,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hht_pkg::SCORE_W-1:0]    out_score
);

  hht_pkg::cmd_t    cmd;
  hht_pkg::status_t status;

  // The controller sequences the sweep and each request; it owns both handshakes.
  hht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the table, the bonus decode, the multiply and the output register.
  hht_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_func        (in_func),
    .in_from_square (in_from_square),
    .in_to_square   (in_to_square),
    .in_depth       (in_depth),
    .out_score      (out_score)
  );

endmodule

[rtl/hht_checker.sv]
`timescale 1ns / 1ps

module hht_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [hht_pkg::SCORE_W-1:0]    out_score
);

  localparam logic signed [hht_pkg::SCORE_W-1:0] LIM = hht_pkg::SCORE_W'(hht_pkg::HIST_LIMIT);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score))
    else $error("result changed while stalled");

  // Scores stay within the saturation bounds.
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_score <= LIM) && (out_score >= -LIM))
    else $error("score outside saturation bounds");

  // One request at a time: an accepted request makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // The clearing pass follows reset, so no request is taken right after it.
  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during clearing pass");

  // A new result appears only at the end of a request's work.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a request in flight");

endmodule

bind history_heuristic_table_update hht_checker u_hht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_score (out_score)
);
